>>> sv/dns_a_record_extractor_core_assert.svh
// Assertion macros for the DNS A-record extractor checker
`ifndef DNS_A_RECORD_EXTRACTOR_CORE_ASSERT_SVH
`define DNS_A_RECORD_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define DAE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dae_checker: same-cycle check failed");

// Next-cycle implication, ignored while reset is held
`define DAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dae_checker: next-cycle check failed");

// Next-cycle implication that also covers reset
`define DAE_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("dae_checker: reset check failed");

`endif

>>> sv/dae_pkg.sv
// Shared types and constants of the DNS A-record extractor
`default_nettype none

package dae_pkg;

    localparam logic [15:0] HEADER_LEN          = 16'd12;
    localparam logic [15:0] QTC_LEN             = 16'd4;
    localparam logic [15:0] REC_TC_FIRST        = 16'd2;
    localparam logic [15:0] REC_TC_LAST         = 16'd5;
    localparam logic [15:0] REC_LEN_HI          = 16'd10;
    localparam logic [15:0] REC_LEN_LO          = 16'd11;
    localparam logic [7:0]  ANSWER_POINTER      = 8'hc0;
    localparam logic [15:0] TYPE_CNAME          = 16'd5;
    localparam logic [31:0] TYPE_CLASS_A_IN     = 32'h0001_0001;
    localparam logic [7:0]  MAX_ADDRESSES_RESET = 8'd16;
    localparam int          RESULT_FIFO_DEPTH   = 4;

    typedef enum logic {
        KIND_ADDRESS = 1'b0,
        KIND_END     = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_QUESTION = 2'd1,
        STATUS_NO_POINTER   = 2'd2,
        STATUS_TRUNCATED    = 2'd3
    } t_status;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  address;
        logic [15:0]  data_length;
        t_status      status;
        logic         last;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

`default_nettype wire

>>> sv/dae_if.sv
// Request channel interfaces: packet bytes in, configuration in, results out
`default_nettype none

interface dae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       end_of_packet;

    modport source (output valid, output packet_byte, output end_of_packet, input ready);
    modport sink (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface dae_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_addresses;

    modport source (output valid, output max_addresses, input ready);
    modport sink (input valid, input max_addresses, output ready);
endinterface

interface dae_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;
    logic [15:0] data_length;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output kind, output address, output data_length,
                    output status, output last, input ready);
    modport sink (input valid, input kind, input address, input data_length,
                  input status, input last, output ready);
endinterface

`default_nettype wire

>>> sv/dae_parser.sv
// Byte-at-a-time DNS response parser: state registers and next-state logic
`default_nettype none

module dae_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_packet_byte,
    input  logic            i_end_of_packet,
    input  logic            i_cfg_write,
    input  logic [7:0]      i_cfg_max_addresses,
    output dae_pkg::t_push  o_push
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QTC,
        PH_FIRST,
        PH_RECORD,
        PH_SKIP,
        PH_ADDR,
        PH_DONE
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_cnt, n_cnt;
    logic [31:0]       r_rtc, n_rtc;
    logic [15:0]       r_rdl, n_rdl;
    logic [31:0]       r_addr, n_addr;
    logic [7:0]        r_reported, n_reported;
    dae_pkg::t_status  r_final, n_final;
    logic [7:0]        r_max, n_max;

    logic [15:0]       w_cnt_inc;
    logic [31:0]       w_rtc_shift;
    logic [31:0]       w_rtc;
    logic [15:0]       w_rdl;
    logic [31:0]       w_addr_shift;
    logic              w_cname;
    dae_pkg::t_status  w_end_status;
    dae_pkg::t_result  w_end;

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_rtc        = r_rtc;
        n_rdl        = r_rdl;
        n_addr       = r_addr;
        n_reported   = r_reported;
        n_final      = r_final;
        n_max        = i_cfg_write ? i_cfg_max_addresses : r_max;
        w_cnt_inc    = r_cnt + 16'd1;
        w_rtc_shift  = {r_rtc[23:0], i_packet_byte};
        w_rtc        = r_rtc;
        w_rdl        = r_rdl;
        w_addr_shift = {r_addr[23:0], i_packet_byte};
        w_cname      = 1'b0;
        w_end_status = dae_pkg::STATUS_OK;
        w_end        = '0;
        o_push       = '0;

        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc >= dae_pkg::HEADER_LEN) begin
                        n_phase = PH_QNAME;
                        n_cnt   = '0;
                    end
                end
                PH_QNAME: begin
                    if (i_packet_byte == 8'd0) begin
                        n_phase = PH_QTC;
                        n_cnt   = '0;
                        n_rtc   = '0;
                    end
                end
                PH_QTC: begin
                    n_rtc = w_rtc_shift;
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc >= dae_pkg::QTC_LEN) begin
                        if (w_rtc_shift == dae_pkg::TYPE_CLASS_A_IN) begin
                            n_phase = PH_FIRST;
                            n_cnt   = '0;
                            n_rtc   = '0;
                        end else begin
                            n_final = dae_pkg::STATUS_BAD_QUESTION;
                            n_phase = PH_DONE;
                            n_cnt   = '0;
                        end
                    end
                end
                PH_FIRST, PH_RECORD: begin
                    if (r_cnt == 16'd0 && r_phase == PH_FIRST &&
                        i_packet_byte != dae_pkg::ANSWER_POINTER) begin
                        n_final = dae_pkg::STATUS_NO_POINTER;
                        n_phase = PH_DONE;
                        n_cnt   = '0;
                    end else begin
                        if (r_cnt inside {[dae_pkg::REC_TC_FIRST:dae_pkg::REC_TC_LAST]}) begin
                            w_rtc = w_rtc_shift;
                        end
                        if (r_cnt inside {dae_pkg::REC_LEN_HI, dae_pkg::REC_LEN_LO}) begin
                            w_rdl = {r_rdl[7:0], i_packet_byte};
                        end
                        n_rtc   = w_rtc;
                        n_rdl   = w_rdl;
                        n_cnt   = w_cnt_inc;
                        w_cname = (r_phase == PH_FIRST) && (w_rtc[31:16] == dae_pkg::TYPE_CNAME);
                        if (r_cnt == dae_pkg::REC_TC_LAST && !w_cname &&
                            !(w_rtc == dae_pkg::TYPE_CLASS_A_IN && r_reported < r_max)) begin
                            n_final = dae_pkg::STATUS_OK;
                            n_phase = PH_DONE;
                            n_cnt   = '0;
                        end else if (r_cnt == dae_pkg::REC_LEN_LO) begin
                            n_cnt  = '0;
                            n_addr = '0;
                            if (w_rdl == 16'd0) begin
                                if (!w_cname) begin
                                    o_push.push0            = 1'b1;
                                    o_push.res0.kind        = dae_pkg::KIND_ADDRESS;
                                    o_push.res0.address     = '0;
                                    o_push.res0.data_length = '0;
                                    o_push.res0.status      = dae_pkg::STATUS_OK;
                                    n_reported              = r_reported + 8'd1;
                                end
                                n_phase = PH_RECORD;
                            end else begin
                                n_phase = w_cname ? PH_SKIP : PH_ADDR;
                            end
                        end
                    end
                end
                PH_SKIP, PH_ADDR: begin
                    n_addr = w_addr_shift;
                    n_cnt  = w_cnt_inc;
                    if (w_cnt_inc >= r_rdl) begin
                        if (r_phase == PH_ADDR) begin
                            o_push.push0            = 1'b1;
                            o_push.res0.kind        = dae_pkg::KIND_ADDRESS;
                            o_push.res0.address     = w_addr_shift;
                            o_push.res0.data_length = r_rdl;
                            o_push.res0.status      = dae_pkg::STATUS_OK;
                            n_reported              = r_reported + 8'd1;
                        end
                        n_phase = PH_RECORD;
                        n_cnt   = '0;
                        n_rtc   = '0;
                        n_rdl   = '0;
                        n_addr  = '0;
                    end
                end
                default: begin
                end
            endcase

            if (i_end_of_packet) begin
                if (n_phase == PH_DONE) begin
                    w_end_status = n_final;
                end else if (n_phase == PH_FIRST && n_cnt == 16'd0) begin
                    w_end_status = dae_pkg::STATUS_NO_POINTER;
                end else if (n_phase == PH_RECORD && n_cnt == 16'd0) begin
                    w_end_status = dae_pkg::STATUS_OK;
                end else begin
                    w_end_status = dae_pkg::STATUS_TRUNCATED;
                end
                w_end.kind        = dae_pkg::KIND_END;
                w_end.address     = '0;
                w_end.data_length = '0;
                w_end.status      = w_end_status;
                w_end.last        = 1'b0;
                if (o_push.push0) begin
                    o_push.push1 = 1'b1;
                    o_push.res1  = w_end;
                end else begin
                    o_push.push0 = 1'b1;
                    o_push.res0  = w_end;
                end
                n_phase    = PH_HEADER;
                n_cnt      = '0;
                n_rtc      = '0;
                n_rdl      = '0;
                n_addr     = '0;
                n_reported = '0;
                n_final    = dae_pkg::STATUS_OK;
            end

            if (o_push.push1) begin
                o_push.res1.last = 1'b1;
            end else if (o_push.push0) begin
                o_push.res0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_cnt      <= '0;
            r_rtc      <= '0;
            r_rdl      <= '0;
            r_addr     <= '0;
            r_reported <= '0;
            r_final    <= dae_pkg::STATUS_OK;
            r_max      <= dae_pkg::MAX_ADDRESSES_RESET;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_rtc      <= n_rtc;
            r_rdl      <= n_rdl;
            r_addr     <= n_addr;
            r_reported <= n_reported;
            r_final    <= n_final;
            r_max      <= n_max;
        end
    end

endmodule

`default_nettype wire

>>> sv/dae_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while i_ready is high
`default_nettype none

module dae_result_fifo #(
    parameter int DEPTH = dae_pkg::RESULT_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dae_pkg::t_push    i_push,
    output logic              o_room_for_two,
    output logic              o_valid,
    input  logic              i_ready,
    output dae_pkg::t_result  o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dae_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    w_wr_ptr1;
    logic [AW-1:0]    w_wr_ptr2;
    logic             w_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    assign w_wr_ptr1      = ptr_inc(r_wr_ptr);
    assign w_wr_ptr2      = ptr_inc(w_wr_ptr1);
    assign o_valid        = (r_count != '0);
    assign o_data         = r_mem[r_rd_ptr];
    assign o_room_for_two = (r_count <= CW'(DEPTH - 2));
    assign w_pop          = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.push1) begin
            n_wr_ptr = w_wr_ptr2;
        end else if (i_push.push0) begin
            n_wr_ptr = w_wr_ptr1;
        end
        n_rd_ptr = w_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> sv/dns_a_record_extractor_core.sv
// Top level of the DNS A-record extractor
//
// i_in carries one DNS response byte per request, with end_of_packet set on
// the final byte. i_cfg writes max_addresses (reset 16) and is always ready;
// write it only between packets. o_out returns results in order: one per
// matching A/IN answer record up to max_addresses (kind 0, address and
// data_length) and one end status per packet (kind 1, status), last set
// on the final result of a byte. A result is registered into the queue as
// its byte is taken; bytes go in one per cycle while i_in.ready is high. A
// byte that both completes a record and ends the packet yields two results.
// Results wait in a queue of RESULT_FIFO_DEPTH entries; i_in.ready drops
// while fewer than two entries are free, so a stalled receiver holds
// o_out steady and backs up the byte stream without losing anything.
// Reset (synchronous, active low) empties the queue, returns the parser to
// the packet header and restores max_addresses to 16.
`default_nettype none

module dns_a_record_extractor_core #(
    parameter int RESULT_FIFO_DEPTH = dae_pkg::RESULT_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dae_in_if.sink      i_in,
    dae_cfg_if.sink     i_cfg,
    dae_out_if.source   o_out
);

    dae_pkg::t_push    w_push;
    dae_pkg::t_result  w_data;
    logic              w_room_for_two;
    logic              w_accept;

    assign i_in.ready  = w_room_for_two;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && w_room_for_two;

    dae_parser u_parser (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (w_accept),
        .i_packet_byte       (i_in.packet_byte),
        .i_end_of_packet     (i_in.end_of_packet),
        .i_cfg_write         (i_cfg.valid),
        .i_cfg_max_addresses (i_cfg.max_addresses),
        .o_push              (w_push)
    );

    dae_result_fifo #(
        .DEPTH (RESULT_FIFO_DEPTH)
    ) u_result_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (w_push),
        .o_room_for_two (w_room_for_two),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_data         (w_data)
    );

    assign o_out.kind        = w_data.kind;
    assign o_out.address     = w_data.address;
    assign o_out.data_length = w_data.data_length;
    assign o_out.status      = w_data.status;
    assign o_out.last        = w_data.last;

endmodule

`default_nettype wire

>>> sv/dae_checker.sv
// Port-level checker for the DNS A-record extractor, bound to the top level
`default_nettype none
`include "dns_a_record_extractor_core_assert.svh"

module dae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [31:0] i_out_address,
    input logic [15:0] i_out_data_length,
    input logic [1:0]  i_out_status,
    input logic        i_out_last
);

    `DAE_ASSERT_RESET(a_reset_empties_queue, !i_rst_n, !i_out_valid)
    `DAE_ASSERT_NOW(a_end_is_last_and_clean, i_out_valid && i_out_kind == dae_pkg::KIND_END, i_out_last && i_out_address == 32'd0 && i_out_data_length == 16'd0)
    `DAE_ASSERT_NOW(a_record_status_ok, i_out_valid && i_out_kind == dae_pkg::KIND_ADDRESS, i_out_status == dae_pkg::STATUS_OK)
    `DAE_ASSERT_NOW(a_backpressure_needs_results, !i_in_ready, i_out_valid)
    `DAE_ASSERT_NEXT(a_stall_holds_result, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_address) && $stable(i_out_data_length) && $stable(i_out_status) && $stable(i_out_last))

endmodule

bind dns_a_record_extractor_core dae_checker u_dae_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_kind        (o_out.kind),
    .i_out_address     (o_out.address),
    .i_out_data_length (o_out.data_length),
    .i_out_status      (o_out.status),
    .i_out_last        (o_out.last)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the DNS A-record extractor: random responses against a predictor
module testbench;

    typedef enum logic [3:0] {
        ST_HEADER,
        ST_NAME,
        ST_QUESTION,
        ST_FIRST_RR,
        ST_RR,
        ST_CNAME_RDATA,
        ST_A_RDATA,
        ST_STOPPED
    } t_parse_state;

    class t_a_record_tracker;
        logic [7:0]         addr_limit = dae_pkg::MAX_ADDRESSES_RESET;
        t_parse_state       ph = ST_HEADER;
        logic [15:0]        byte_idx = '0;
        logic [31:0]        type_class = '0;
        logic [15:0]        rdata_len = '0;
        logic [31:0]        rdata = '0;
        logic [7:0]         reported = '0;
        dae_pkg::t_status   stop_status = dae_pkg::STATUS_OK;
        dae_pkg::t_result   pending_results[$];
        int                 mismatches = 0;
        int                 address_count = 0;
        int                 end_count = 0;

        function void restart();
            ph = ST_HEADER;
            byte_idx = '0;
            type_class = '0;
            rdata_len = '0;
            rdata = '0;
            reported = '0;
            stop_status = dae_pkg::STATUS_OK;
        endfunction

        function void halt(dae_pkg::t_status st);
            stop_status = st;
            ph = ST_STOPPED;
            byte_idx = '0;
        endfunction

        function void queue_result(dae_pkg::t_kind k, logic [31:0] a, logic [15:0] l,
                                   dae_pkg::t_status st);
            dae_pkg::t_result fresh;
            fresh.kind = k;
            fresh.address = a;
            fresh.data_length = l;
            fresh.status = st;
            fresh.last = 1'b0;
            pending_results.push_back(fresh);
        endfunction

        function void take_byte(logic [7:0] b, logic eop);
            int               first_new;
            logic [15:0]      c;
            bit               cname;
            dae_pkg::t_status st;
            first_new = pending_results.size();
            case (ph)
                ST_HEADER: begin
                    byte_idx = byte_idx + 16'd1;
                    if (byte_idx >= dae_pkg::HEADER_LEN) begin
                        ph = ST_NAME;
                        byte_idx = '0;
                    end
                end
                ST_NAME: begin
                    if (b == 8'h00) begin
                        ph = ST_QUESTION;
                        byte_idx = '0;
                        type_class = '0;
                    end
                end
                ST_QUESTION: begin
                    type_class = {type_class[23:0], b};
                    byte_idx = byte_idx + 16'd1;
                    if (byte_idx >= dae_pkg::QTC_LEN) begin
                        if (type_class == dae_pkg::TYPE_CLASS_A_IN) begin
                            ph = ST_FIRST_RR;
                            byte_idx = '0;
                            type_class = '0;
                        end else begin
                            halt(dae_pkg::STATUS_BAD_QUESTION);
                        end
                    end
                end
                ST_FIRST_RR, ST_RR: begin
                    c = byte_idx;
                    if (c == 0 && ph == ST_FIRST_RR && b != dae_pkg::ANSWER_POINTER) begin
                        halt(dae_pkg::STATUS_NO_POINTER);
                    end else begin
                        if (c >= dae_pkg::REC_TC_FIRST && c <= dae_pkg::REC_TC_LAST)
                            type_class = {type_class[23:0], b};
                        if (c == dae_pkg::REC_LEN_HI || c == dae_pkg::REC_LEN_LO)
                            rdata_len = {rdata_len[7:0], b};
                        byte_idx = c + 16'd1;
                        cname = (ph == ST_FIRST_RR) &&
                                (type_class[31:16] == dae_pkg::TYPE_CNAME);
                        if (c == dae_pkg::REC_TC_LAST && !cname &&
                            !(type_class == dae_pkg::TYPE_CLASS_A_IN &&
                              reported < addr_limit)) begin
                            halt(dae_pkg::STATUS_OK);
                        end else if (c == dae_pkg::REC_LEN_LO) begin
                            byte_idx = '0;
                            rdata = '0;
                            if (rdata_len == 0) begin
                                if (!cname) begin
                                    queue_result(dae_pkg::KIND_ADDRESS, '0, '0,
                                                 dae_pkg::STATUS_OK);
                                    reported = reported + 8'd1;
                                end
                                ph = ST_RR;
                            end else begin
                                ph = cname ? ST_CNAME_RDATA : ST_A_RDATA;
                            end
                        end
                    end
                end
                ST_CNAME_RDATA, ST_A_RDATA: begin
                    rdata = {rdata[23:0], b};
                    byte_idx = byte_idx + 16'd1;
                    if (byte_idx >= rdata_len) begin
                        if (ph == ST_A_RDATA) begin
                            queue_result(dae_pkg::KIND_ADDRESS, rdata, rdata_len,
                                         dae_pkg::STATUS_OK);
                            reported = reported + 8'd1;
                        end
                        ph = ST_RR;
                        byte_idx = '0;
                        type_class = '0;
                        rdata_len = '0;
                        rdata = '0;
                    end
                end
                default: begin
                end
            endcase

            if (eop) begin
                if (ph == ST_STOPPED)
                    st = stop_status;
                else if (ph == ST_FIRST_RR && byte_idx == 0)
                    st = dae_pkg::STATUS_NO_POINTER;
                else if (ph == ST_RR && byte_idx == 0)
                    st = dae_pkg::STATUS_OK;
                else
                    st = dae_pkg::STATUS_TRUNCATED;
                queue_result(dae_pkg::KIND_END, '0, '0, st);
                restart();
            end
            if (pending_results.size() > first_new)
                pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(dae_pkg::t_result got);
            dae_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d address 0x%0h data_length %0d status %0d",
                       got.kind, got.address, got.data_length, got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare("kind", want.kind, got.kind);
            compare("address", want.address, got.address);
            compare("data_length", want.data_length, got.data_length);
            compare("status", want.status, got.status);
            compare("last", want.last, got.last);
            if (got.kind == dae_pkg::KIND_ADDRESS)
                address_count++;
            else
                end_count++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dae_in_if  in_bus();
    dae_cfg_if cfg_bus();
    dae_out_if out_bus();

    dns_a_record_extractor_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    t_a_record_tracker tracker;
    logic [7:0]        frame[$];
    bit                hold_off_req = 1'b0;
    int                bytes_sent = 0;
    int                packets_sent = 0;
    int                settings_used = 0;

    always #5 i_clk = ~i_clk;

    task automatic send_byte(input logic [7:0] b, input logic eop, input bit steady);
        int gap;
        in_bus.valid <= 1'b1;
        in_bus.packet_byte <= b;
        in_bus.end_of_packet <= eop;
        do @(posedge i_clk); while (!in_bus.ready);
        tracker.take_byte(b, eop);
        bytes_sent++;
        gap = 0;
        if (!steady) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: gap = $urandom_range(1, 3);
                4:          gap = $urandom_range(8, 30);
                default:    gap = 0;
            endcase
        end
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame();
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1, steady);
        packets_sent++;
    endtask

    task automatic write_limit(input logic [7:0] value);
        in_bus.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.max_addresses <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        tracker.addr_limit = value;
        settings_used++;
    endtask

    task automatic add_record(input logic [15:0] rtype, input logic [15:0] rclass,
                              input logic [15:0] len, input int data_bytes);
        frame.push_back(dae_pkg::ANSWER_POINTER);
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(rtype[15:8]);
        frame.push_back(rtype[7:0]);
        frame.push_back(rclass[15:8]);
        frame.push_back(rclass[7:0]);
        repeat (4) frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(len[15:8]);
        frame.push_back(len[7:0]);
        repeat (data_bytes < 0 ? int'(len) : data_bytes)
            frame.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_response(input bit many);
        int          n_rr;
        int          pick;
        int          n;
        logic [15:0] len;
        frame.delete();
        if (!many && $urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat (int'(dae_pkg::HEADER_LEN)) frame.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) begin
            n = $urandom_range(1, 5);
            frame.push_back(8'(n));
            repeat (n) frame.push_back(8'($urandom_range(1, 255)));
        end
        frame.push_back(8'h00);
        if (!many && $urandom_range(0, 9) == 0) begin
            repeat (4) frame.push_back(8'($urandom_range(0, 255)));
        end else begin
            frame.push_back(dae_pkg::TYPE_CLASS_A_IN[31:24]);
            frame.push_back(dae_pkg::TYPE_CLASS_A_IN[23:16]);
            frame.push_back(dae_pkg::TYPE_CLASS_A_IN[15:8]);
            frame.push_back(dae_pkg::TYPE_CLASS_A_IN[7:0]);
        end
        n_rr = many ? $urandom_range(17, 19) : $urandom_range(0, 3);
        if (!many && $urandom_range(0, 19) == 0) begin
            frame.push_back(8'($urandom_range(0, 191)));
            repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0)
                add_record(dae_pkg::TYPE_CNAME, 16'($urandom), 16'($urandom_range(0, 6)), -1);
            for (int i = 0; i < n_rr; i++) begin
                pick = $urandom_range(0, 19);
                if (!many && pick == 0) begin
                    add_record(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8)), -1);
                end else if (!many && pick == 1) begin
                    add_record(dae_pkg::TYPE_CLASS_A_IN[31:16], dae_pkg::TYPE_CLASS_A_IN[15:0],
                               16'($urandom_range(9, 65535)), $urandom_range(0, 12));
                end else begin
                    if (many)
                        len = 16'($urandom_range(0, 4));
                    else if (pick < 15)
                        len = 16'd4;
                    else if (pick < 18)
                        len = 16'd0;
                    else
                        len = 16'($urandom_range(1, 8));
                    add_record(dae_pkg::TYPE_CLASS_A_IN[31:16], dae_pkg::TYPE_CLASS_A_IN[15:0],
                               len, -1);
                end
            end
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
        if (!many && frame.size() > 1 && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, frame.size() - 1);
            while (frame.size() > n) void'(frame.pop_back());
        end
    endtask

    always @(posedge i_clk) begin
        dae_pkg::t_result got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.kind = dae_pkg::t_kind'(out_bus.kind);
            got.address = out_bus.address;
            got.data_length = out_bus.data_length;
            got.status = dae_pkg::t_status'(out_bus.status);
            got.last = out_bus.last;
            tracker.match_result(got);
        end
    end

    initial begin
        int r;
        out_bus.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_bus.ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (r < 65) begin
                    out_bus.ready <= 1'b1;
                    repeat ($urandom_range(30, 80)) @(posedge i_clk);
                end else if (r < 95) begin
                    out_bus.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    out_bus.ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int setting;
        bit many;
        tracker = new;
        i_rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.packet_byte <= 8'h00;
        in_bus.end_of_packet <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.max_addresses <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        frame = '{8'hff};
        send_frame();
        frame.delete();
        for (int i = 0; i < int'(dae_pkg::HEADER_LEN); i++)
            frame.push_back(i % 2 ? 8'hff : 8'h00);
        frame.push_back(8'h00);
        frame.push_back(dae_pkg::TYPE_CLASS_A_IN[31:24]);
        frame.push_back(dae_pkg::TYPE_CLASS_A_IN[23:16]);
        frame.push_back(dae_pkg::TYPE_CLASS_A_IN[15:8]);
        frame.push_back(dae_pkg::TYPE_CLASS_A_IN[7:0]);
        send_frame();

        for (int p = 0; bytes_sent < 1050; p++) begin
            if (p > 0) begin
                case (p)
                    1:       setting = 0;
                    2:       setting = 255;
                    3:       setting = 1;
                    4:       setting = 2;
                    default: setting = $urandom_range(0, 1) ? $urandom_range(0, 4)
                                                            : $urandom_range(0, 255);
                endcase
                write_limit(8'(setting));
            end
            for (int k = 0; k < 3 && (bytes_sent < 1050 || p <= 2); k++) begin
                many = (p == 0 && k == 2) || (p == 2 && k == 0);
                if (p == 2 && k == 0)
                    hold_off_req = 1'b1;
                build_response(many);
                send_frame();
            end
        end

        in_bus.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d responses (%0d bytes) under %0d address limit settings",
                 packets_sent, bytes_sent, settings_used + 1);
        $display("Checked %0d address records and %0d end statuses",
                 tracker.address_count, tracker.end_count);
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
